// File: rtl/infix_arith_expression_eval_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the infix expression evaluator
// Clocked assertion shorthands; the including module supplies clock and reset.
// ----------------------------------------------------------------------------
`ifndef INFIX_ARITH_EXPRESSION_EVAL_UNIT_MACROS_SVH
`define INFIX_ARITH_EXPRESSION_EVAL_UNIT_MACROS_SVH

// Checked on every clock edge outside reset.
`define IAE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every clock edge, reset included.
`define IAE_ASSERT_NR(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/iae_pkg.sv
// ----------------------------------------------------------------------------
// iae_pkg
// Formats, character codes, status codes, states and the power-of-ten table
// of the infix expression evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iae_pkg;

   // Fixed-point format
   localparam int FRAC_BITS       = 16;
   localparam int INT_BITS        = 31;
   localparam int MAX_FRAC_DIGITS = 6;

   localparam int VAL_W      = INT_BITS + FRAC_BITS + 1;
   localparam int NUM_INT_W  = 32;
   localparam int FRAC_NUM_W = $clog2(10 ** MAX_FRAC_DIGITS);
   localparam int FRAC_CNT_W = $clog2(MAX_FRAC_DIGITS + 1);
   localparam int DIVD_W     = VAL_W + FRAC_BITS;
   localparam int PROD_W     = 2 * VAL_W;
   localparam int ALU_W      = VAL_W + 2;
   localparam int MUL_STEPS  = VAL_W;
   localparam int DIV_STEPS  = DIVD_W;
   localparam int STEP_CNT_W = $clog2(DIVD_W);

   localparam logic [VAL_W-1:0] MAX_VAL = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] MIN_VAL = {1'b1, {(VAL_W-1){1'b0}}};

   // Characters
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_INVALID = 2'd1;
   localparam logic [1:0] STAT_DIV0    = 2'd2;
   localparam logic [1:0] STAT_OVF     = 2'd3;

   // Pending multiplicative operator
   localparam logic [1:0] MULOP_NONE = 2'd0;
   localparam logic [1:0] MULOP_MUL  = 2'd1;
   localparam logic [1:0] MULOP_DIV  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,  // waiting for a character
      ST_OPND,  // start closing the current operand
      ST_NDIV,  // fraction digits / 10^k, one quotient bit a cycle
      ST_NVAL,  // operand value ready, dispatch pending operator
      ST_MUL,   // shift-add multiply, one bit a cycle
      ST_DIV,   // restoring divide, one bit a cycle
      ST_MFIN,  // sign and saturate product or quotient
      ST_NEXT,  // decide on term close or new pending operator
      ST_TERM,  // add or subtract term into the sum
      ST_OUT    // hand result to the output register
   } state_type;

   function automatic logic [FRAC_NUM_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] k);
      logic [FRAC_NUM_W+3:0] p;
      p = (FRAC_NUM_W+4)'(1);
      for (int i = 0; i < MAX_FRAC_DIGITS; i++) begin
         if (i < int'(k)) begin
            p = (p << 3) + (p << 1);
         end
      end
      return p[FRAC_NUM_W-1:0];
   endfunction

endpackage

// File: rtl/infix_arith_expression_eval_unit.sv
// ----------------------------------------------------------------------------
// infix_arith_expression_eval_unit
// Streaming evaluator of + - * / expressions in signed Q31.16 fixed point.
//
// Requests carry one ASCII character (req_char_code) and an end marker
// (req_is_last). A request is taken when req_valid is high and req_stall low.
// Digits, dots and unknown characters are absorbed in the idle state. An operator or
// the last character closes the operand: operand setup, a divide of the
// fraction digits by 10^k for a number with fraction digits, the operand
// value and dispatch, a multiply or divide if one is pending, and the sign
// fix-up and term add where they apply; a last request that is an operator
// adds one more operand/term pass; then the response register is loaded.
// All iterations run one bit a cycle through a single 50-bit add/subtract
// unit; req_stall is high for the whole pass.
// One response per expression: rsp_value (result, saturated) and rsp_status
// (ok, invalid character, divide by zero, overflow). The response sits in an
// output register; while rsp_stall holds it, new characters are still taken
// and only the next response waits. Synchronous reset clears the evaluator
// and drops any pending response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "infix_arith_expression_eval_unit_macros.svh"

module infix_arith_expression_eval_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_char_code,
   input  logic                               req_is_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [iae_pkg::VAL_W-1:0]   rsp_value,
   output logic [1:0]                         rsp_status
);

   // Sequencer and request context
   iae_pkg::state_type state_ff, state_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       final_ff, final_in;   // closing the expression, not an operator

   // Evaluator state
   logic [iae_pkg::VAL_W-1:0]      sum_ff, sum_in;
   logic [iae_pkg::VAL_W-1:0]      term_ff, term_in;
   logic                           sign_ff, sign_in;
   logic [1:0]                     mulop_ff, mulop_in;
   logic [iae_pkg::NUM_INT_W-1:0]  int_ff, int_in;
   logic [iae_pkg::FRAC_NUM_W-1:0] frac_ff, frac_in;
   logic [iae_pkg::FRAC_CNT_W-1:0] fdig_ff, fdig_in;
   logic                           dot_ff, dot_in;
   logic [1:0]                     err_ff, err_in;

   // Iterative multiply/divide datapath
   logic [iae_pkg::VAL_W-1:0]      mag_ff, mag_in;  // multiplicand or divisor
   logic                           neg_ff, neg_in;
   logic [iae_pkg::VAL_W-1:0]      hi_ff, hi_in;    // partial product or remainder
   logic [iae_pkg::DIVD_W-1:0]     lo_ff, lo_in;    // multiplier or dividend/quotient
   logic [iae_pkg::STEP_CNT_W-1:0] cnt_ff, cnt_in;

   // Output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [iae_pkg::VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;

   // Shared add/subtract unit
   logic [iae_pkg::ALU_W-1:0] alu_a, alu_b, alu_y;
   logic                      alu_sub;
   logic                      div_borrow;

   // Helpers
   logic [3:0]                       digit;
   logic [iae_pkg::NUM_INT_W+3:0]    int_x10;
   logic [iae_pkg::FRAC_NUM_W+3:0]   frac_x10;
   logic [iae_pkg::VAL_W-1:0]        term_mag;
   logic [iae_pkg::PROD_W-1:0]       nv_ext;
   logic                             nv_ovf;
   logic [iae_pkg::VAL_W-1:0]        nv_sat;
   logic [iae_pkg::PROD_W-1:0]       res_mag, res_limit;
   logic                             res_ovf;
   logic [iae_pkg::VAL_W-1:0]        res_val;
   logic                             sum_ovf;
   logic [iae_pkg::VAL_W-1:0]        sum_sat;

   // ---------------------------------------------------------------------
   // Digit accumulation: n*10 + d as shift-and-add
   // ---------------------------------------------------------------------
   assign digit    = 4'(req_char_code - iae_pkg::CH_ZERO);
   assign int_x10  = ({4'b0, int_ff} << 3) + ({4'b0, int_ff} << 1)
                   + (iae_pkg::NUM_INT_W+4)'(digit);
   assign frac_x10 = ({4'b0, frac_ff} << 3) + ({4'b0, frac_ff} << 1)
                   + (iae_pkg::FRAC_NUM_W+4)'(digit);

   // Operand value: integer part above the binary point, fraction quotient below
   assign nv_ext = iae_pkg::PROD_W'({int_ff, lo_ff[iae_pkg::FRAC_BITS-1:0]});
   assign nv_ovf = nv_ext > iae_pkg::PROD_W'(iae_pkg::MAX_VAL);
   assign nv_sat = nv_ovf ? iae_pkg::MAX_VAL : nv_ext[iae_pkg::VAL_W-1:0];

   // Magnitude of the running term (most negative value maps to 2^(W-1))
   assign term_mag = term_ff[iae_pkg::VAL_W-1] ? (~term_ff + 1'b1) : term_ff;

   // Product is rescaled by the fraction width; quotient is already scaled
   assign res_mag   = (mulop_ff == iae_pkg::MULOP_MUL)
                    ? ({hi_ff, lo_ff[iae_pkg::VAL_W-1:0]} >> iae_pkg::FRAC_BITS)
                    : iae_pkg::PROD_W'(lo_ff);
   assign res_limit = iae_pkg::PROD_W'(iae_pkg::MAX_VAL) + iae_pkg::PROD_W'(neg_ff);
   assign res_ovf   = res_mag > res_limit;
   assign res_val   = res_ovf ? (neg_ff ? iae_pkg::MIN_VAL : iae_pkg::MAX_VAL)
                    : (neg_ff ? (~res_mag[iae_pkg::VAL_W-1:0] + 1'b1)
                              : res_mag[iae_pkg::VAL_W-1:0]);

   // ---------------------------------------------------------------------
   // Shared add/subtract unit
   // ---------------------------------------------------------------------
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         iae_pkg::ST_MUL: begin
            alu_a = iae_pkg::ALU_W'(hi_ff);
            alu_b = lo_ff[0] ? iae_pkg::ALU_W'(mag_ff) : '0;
         end
         iae_pkg::ST_NDIV, iae_pkg::ST_DIV: begin
            alu_a   = iae_pkg::ALU_W'({hi_ff, lo_ff[iae_pkg::DIVD_W-1]});
            alu_b   = iae_pkg::ALU_W'(mag_ff);
            alu_sub = 1'b1;
         end
         iae_pkg::ST_TERM: begin
            alu_a   = {{2{sum_ff[iae_pkg::VAL_W-1]}}, sum_ff};
            alu_b   = {{2{term_ff[iae_pkg::VAL_W-1]}}, term_ff};
            alu_sub = sign_ff;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   assign alu_y      = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   assign div_borrow = alu_y[iae_pkg::ALU_W-1];

   // Term accumulate: exact in W+2 bits, saturate back to W
   assign sum_ovf = !((alu_y[iae_pkg::ALU_W-1:iae_pkg::VAL_W-1] == '0) ||
                      (alu_y[iae_pkg::ALU_W-1:iae_pkg::VAL_W-1] == '1));
   assign sum_sat = sum_ovf ? (alu_y[iae_pkg::ALU_W-1] ? iae_pkg::MIN_VAL : iae_pkg::MAX_VAL)
                            : alu_y[iae_pkg::VAL_W-1:0];

   // ---------------------------------------------------------------------
   // Sequencer: next state and datapath control
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      char_in       = char_ff;
      last_in       = last_ff;
      final_in      = final_ff;
      sum_in        = sum_ff;
      term_in       = term_ff;
      sign_in       = sign_ff;
      mulop_in      = mulop_ff;
      int_in        = int_ff;
      frac_in       = frac_ff;
      fdig_in       = fdig_ff;
      dot_in        = dot_ff;
      err_in        = err_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         iae_pkg::ST_IDLE: begin
            if (req_valid) begin
               char_in  = req_char_code;
               last_in  = req_is_last;
               final_in = 1'b1;
               if (req_char_code inside {[iae_pkg::CH_ZERO:iae_pkg::CH_NINE]}) begin
                  if (!dot_ff) begin
                     if (int_x10[iae_pkg::NUM_INT_W+3:iae_pkg::NUM_INT_W] != '0) begin
                        int_in = '1;
                        if (err_in == iae_pkg::STAT_OK) err_in = iae_pkg::STAT_OVF;
                     end else begin
                        int_in = int_x10[iae_pkg::NUM_INT_W-1:0];
                     end
                  end else if (fdig_ff < iae_pkg::FRAC_CNT_W'(iae_pkg::MAX_FRAC_DIGITS)) begin
                     frac_in = frac_x10[iae_pkg::FRAC_NUM_W-1:0];
                     fdig_in = fdig_ff + 1'b1;
                  end
               end else if (req_char_code == iae_pkg::CH_DOT) begin
                  if (dot_ff && (err_in == iae_pkg::STAT_OK)) err_in = iae_pkg::STAT_INVALID;
                  dot_in = 1'b1;
               end else if (req_char_code inside {iae_pkg::CH_PLUS, iae_pkg::CH_MINUS,
                                                  iae_pkg::CH_STAR, iae_pkg::CH_SLASH}) begin
                  final_in = 1'b0;
               end else begin
                  if (err_in == iae_pkg::STAT_OK) err_in = iae_pkg::STAT_INVALID;
               end
               if (!final_in || req_is_last) state_in = iae_pkg::ST_OPND;
            end
         end

         iae_pkg::ST_OPND: begin
            hi_in = '0;
            if (fdig_ff != '0) begin
               mag_in   = iae_pkg::VAL_W'(iae_pkg::pow10(fdig_ff));
               lo_in    = iae_pkg::DIVD_W'({frac_ff, {iae_pkg::FRAC_BITS{1'b0}}});
               cnt_in   = iae_pkg::STEP_CNT_W'(iae_pkg::DIV_STEPS - 1);
               state_in = iae_pkg::ST_NDIV;
            end else begin
               lo_in    = '0;
               state_in = iae_pkg::ST_NVAL;
            end
         end

         iae_pkg::ST_NDIV, iae_pkg::ST_DIV: begin
            hi_in = div_borrow ? alu_a[iae_pkg::VAL_W-1:0] : alu_y[iae_pkg::VAL_W-1:0];
            lo_in = {lo_ff[iae_pkg::DIVD_W-2:0], !div_borrow};
            if (cnt_ff == '0) begin
               state_in = (state_ff == iae_pkg::ST_NDIV) ? iae_pkg::ST_NVAL : iae_pkg::ST_MFIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end

         iae_pkg::ST_MUL: begin
            hi_in                     = alu_y[iae_pkg::VAL_W:1];
            lo_in                     = lo_ff >> 1;
            lo_in[iae_pkg::VAL_W-1]   = alu_y[0];
            if (cnt_ff == '0) begin
               state_in = iae_pkg::ST_MFIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end

         iae_pkg::ST_NVAL: begin
            if (nv_ovf && (err_in == iae_pkg::STAT_OK)) err_in = iae_pkg::STAT_OVF;
            int_in  = '0;
            frac_in = '0;
            fdig_in = '0;
            dot_in  = 1'b0;
            hi_in   = '0;
            neg_in  = term_ff[iae_pkg::VAL_W-1];
            case (mulop_ff)
               iae_pkg::MULOP_MUL: begin
                  mag_in   = term_mag;
                  lo_in    = iae_pkg::DIVD_W'(nv_sat);
                  cnt_in   = iae_pkg::STEP_CNT_W'(iae_pkg::MUL_STEPS - 1);
                  state_in = iae_pkg::ST_MUL;
               end
               iae_pkg::MULOP_DIV: begin
                  if (nv_sat == '0) begin
                     if (err_in == iae_pkg::STAT_OK) err_in = iae_pkg::STAT_DIV0;
                     term_in  = '0;
                     state_in = iae_pkg::ST_NEXT;
                  end else begin
                     mag_in   = nv_sat;
                     lo_in    = {term_mag, {iae_pkg::FRAC_BITS{1'b0}}};
                     cnt_in   = iae_pkg::STEP_CNT_W'(iae_pkg::DIV_STEPS - 1);
                     state_in = iae_pkg::ST_DIV;
                  end
               end
               default: begin
                  // no operator pending: operand starts the term
                  term_in  = nv_sat;
                  state_in = iae_pkg::ST_NEXT;
               end
            endcase
         end

         iae_pkg::ST_MFIN: begin
            term_in = res_val;
            if (res_ovf && (err_in == iae_pkg::STAT_OK)) err_in = iae_pkg::STAT_OVF;
            state_in = iae_pkg::ST_NEXT;
         end

         iae_pkg::ST_NEXT: begin
            if (final_ff || (char_ff == iae_pkg::CH_PLUS) || (char_ff == iae_pkg::CH_MINUS)) begin
               state_in = iae_pkg::ST_TERM;
            end else begin
               mulop_in = (char_ff == iae_pkg::CH_STAR) ? iae_pkg::MULOP_MUL
                                                        : iae_pkg::MULOP_DIV;
               if (last_ff) begin
                  final_in = 1'b1;
                  state_in = iae_pkg::ST_OPND;
               end else begin
                  state_in = iae_pkg::ST_IDLE;
               end
            end
         end

         iae_pkg::ST_TERM: begin
            sum_in  = sum_sat;
            if (sum_ovf && (err_in == iae_pkg::STAT_OK)) err_in = iae_pkg::STAT_OVF;
            term_in = '0;
            if (final_ff) begin
               state_in = iae_pkg::ST_OUT;
            end else begin
               sign_in  = (char_ff == iae_pkg::CH_MINUS);
               mulop_in = iae_pkg::MULOP_NONE;
               if (last_ff) begin
                  final_in = 1'b1;
                  state_in = iae_pkg::ST_OPND;
               end else begin
                  state_in = iae_pkg::ST_IDLE;
               end
            end
         end

         iae_pkg::ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = ((err_ff == iae_pkg::STAT_INVALID) ||
                                (err_ff == iae_pkg::STAT_DIV0)) ? '0 : sum_ff;
               rsp_status_in = err_ff;
               sum_in        = '0;
               term_in       = '0;
               sign_in       = 1'b0;
               mulop_in      = iae_pkg::MULOP_NONE;
               err_in        = iae_pkg::STAT_OK;
               state_in      = iae_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = iae_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iae_pkg::ST_IDLE;
         last_ff      <= 1'b0;
         final_ff     <= 1'b0;
         sum_ff       <= '0;
         term_ff      <= '0;
         sign_ff      <= 1'b0;
         mulop_ff     <= iae_pkg::MULOP_NONE;
         int_ff       <= '0;
         frac_ff      <= '0;
         fdig_ff      <= '0;
         dot_ff       <= 1'b0;
         err_ff       <= iae_pkg::STAT_OK;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         final_ff     <= final_in;
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         sign_ff      <= sign_in;
         mulop_ff     <= mulop_in;
         int_ff       <= int_in;
         frac_ff      <= frac_in;
         fdig_ff      <= fdig_in;
         dot_ff       <= dot_in;
         err_ff       <= err_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and payload, no reset
   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      hi_ff         <= hi_in;
      lo_ff         <= lo_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall  = (state_ff != iae_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = signed'(rsp_value_ff);
   assign rsp_status = rsp_status_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `IAE_ASSERT_NR(a_reset_idle,
      reset |=> ((state_ff == iae_pkg::ST_IDLE) && !rsp_valid),
      "reset did not clear sequencer or response")
   `IAE_ASSERT(a_rsp_from_out,
      $rose(rsp_valid) |-> $past(state_ff == iae_pkg::ST_OUT),
      "response raised outside output state")
   `IAE_ASSERT(a_last_busy,
      (req_valid && !req_stall && req_is_last) |=> (state_ff != iae_pkg::ST_IDLE),
      "last request did not start evaluation")
   `IAE_ASSERT(a_err_sticky,
      ((err_ff != iae_pkg::STAT_OK) && (state_ff != iae_pkg::ST_OUT)) |=> $stable(err_ff),
      "first recorded error was overwritten")
   `IAE_ASSERT(a_err_zero,
      (rsp_valid && ((rsp_status == iae_pkg::STAT_INVALID) ||
                     (rsp_status == iae_pkg::STAT_DIV0))) |-> (rsp_value == '0),
      "error response with nonzero value")

endmodule
